@@ rtl/assert_macros.svh @@
// assertion macros used by the alpha over blend top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define AOB_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// consequent checked in the cycle after the antecedent
`define AOB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

@@ rtl/aob_pkg.sv @@
// types and constants of the alpha over blend block
`default_nettype none

package aob_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int COORD_W      = 13;
    localparam int CLIP_W       = 13;
    localparam int WEIGHT_W     = 9;
    localparam int DEN_W        = 2 * CHANNEL_BITS;
    localparam int NUM_W        = 3 * CHANNEL_BITS;
    localparam int NUM_CH       = 3;
    localparam int DIV_STEPS    = CHANNEL_BITS;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CHANNEL_BITS-1:0] CH_MAX     = 8'd255;
    localparam logic [CLIP_W-1:0]       CLIP_RESET = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_WIDTH  = 1'b0,
        CFG_CLIP_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [NUM_CH-1:0][NUM_W-1:0]        num_vec_t;
    typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] chan_vec_t;

    // per-item flags that travel beside the divider
    typedef struct packed {
        logic                    in_clip;
        logic                    nonzero;
        logic [CHANNEL_BITS-1:0] alpha;
    } aob_side_t;

endpackage

`default_nettype wire

@@ rtl/alpha_over_blend_top.sv @@
// top level of the alpha over blend pipeline
`default_nettype none

`include "assert_macros.svh"

// Straight-alpha "over" compositing of one source color onto one RGBA8888
// destination pixel. The source alpha is first weighted as
// Sa = min((src_alpha * weight) >> 8, 255), so weight 256 gives the plain blend.
// With D = 255*Sa + Da*(255-Sa) the result alpha is floor(D/255) and each
// color is floor((Cs*Sa*255 + Cd*Da*(255-Sa)) / D), all exact and truncating.
// D of zero gives all-zero channels with the write still enabled. A pixel with
// x or y below zero or at/above clip_width/clip_height returns one transaction
// with write_enable low and all channels zero. Every input transaction yields
// exactly one output transaction, in order. Throughput is one transaction per
// clock while m_ready does not hold the output; the stages are the input stage
// (clip compare, alpha weighting), denominator and product stage, numerator
// stage, eight steps of the restoring divider (one quotient bit each), and the
// output register. When the output is held off by m_ready low the whole
// pipeline freezes, so s_ready follows m_ready whenever the output register is
// full. The clip registers are written through cfg_we/cfg_index/cfg_wdata and
// reset to 4096; write them only when the pipeline is empty.
module alpha_over_blend_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration writes
    input  wire logic                                  cfg_we,
    input  wire logic [aob_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [aob_pkg::CLIP_W-1:0]            cfg_wdata,
    // input transactions
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [aob_pkg::COORD_W-1:0]    s_x_pos,
    input  wire logic signed [aob_pkg::COORD_W-1:0]    s_y_pos,
    input  wire logic [aob_pkg::CHANNEL_BITS-1:0]      s_dest_red,
    input  wire logic [aob_pkg::CHANNEL_BITS-1:0]      s_dest_green,
    input  wire logic [aob_pkg::CHANNEL_BITS-1:0]      s_dest_blue,
    input  wire logic [aob_pkg::CHANNEL_BITS-1:0]      s_dest_alpha,
    input  wire logic [aob_pkg::CHANNEL_BITS-1:0]      s_src_red,
    input  wire logic [aob_pkg::CHANNEL_BITS-1:0]      s_src_green,
    input  wire logic [aob_pkg::CHANNEL_BITS-1:0]      s_src_blue,
    input  wire logic [aob_pkg::CHANNEL_BITS-1:0]      s_src_alpha,
    input  wire logic [aob_pkg::WEIGHT_W-1:0]          s_weight,
    // output transactions
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_write_enable,
    output logic [aob_pkg::CHANNEL_BITS-1:0]           m_out_red,
    output logic [aob_pkg::CHANNEL_BITS-1:0]           m_out_green,
    output logic [aob_pkg::CHANNEL_BITS-1:0]           m_out_blue,
    output logic [aob_pkg::CHANNEL_BITS-1:0]           m_out_alpha
);

    localparam int CB    = aob_pkg::CHANNEL_BITS;
    localparam int CW    = aob_pkg::COORD_W;
    localparam int DW    = aob_pkg::DEN_W;
    localparam int NW    = aob_pkg::NUM_W;
    localparam int NCH   = aob_pkg::NUM_CH;
    localparam int STEPS = aob_pkg::DIV_STEPS;
    localparam int PW    = CB + aob_pkg::WEIGHT_W;

    // ---------------------------------------------------------------
    // clip registers
    // ---------------------------------------------------------------
    logic [aob_pkg::CLIP_W-1:0] clip_width_reg;
    logic [aob_pkg::CLIP_W-1:0] clip_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_width_reg  <= aob_pkg::CLIP_RESET;
            clip_height_reg <= aob_pkg::CLIP_RESET;
        end else if (cfg_we) begin
            case (aob_pkg::cfg_index_t'(cfg_index))
                aob_pkg::CFG_CLIP_WIDTH:  clip_width_reg  <= cfg_wdata;
                aob_pkg::CFG_CLIP_HEIGHT: clip_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline advance: everything moves when the output slot is free
    // ---------------------------------------------------------------
    logic adv;
    logic m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------------------------------------------------------
    // stage 1: clip test and alpha weighting
    // ---------------------------------------------------------------
    logic          v1_reg;
    logic          inside1_reg;
    logic [CB-1:0] sa1_reg;
    logic [CB-1:0] da1_reg;
    aob_pkg::chan_vec_t cs1_reg;
    aob_pkg::chan_vec_t cd1_reg;

    logic          inside1_next;
    logic          x_in, y_in;
    logic [PW-1:0] sa_prod;
    logic [CB-1:0] sa1_next;

    // negative coordinates fail on the sign bit, the rest compare unsigned
    assign x_in = !s_x_pos[CW-1] && ({1'b0, s_x_pos[CW-2:0]} < clip_width_reg);
    assign y_in = !s_y_pos[CW-1] && ({1'b0, s_y_pos[CW-2:0]} < clip_height_reg);
    assign inside1_next = x_in && y_in;

    assign sa_prod  = PW'(s_src_alpha) * PW'(s_weight);
    // weights above 256 can push the product past full scale
    assign sa1_next = sa_prod[PW-1] ? aob_pkg::CH_MAX : sa_prod[PW-2:CB];

    always_ff @(posedge aclk) begin
        if (adv) begin
            inside1_reg <= inside1_next;
            sa1_reg     <= sa1_next;
            da1_reg     <= s_dest_alpha;
            cs1_reg     <= {s_src_blue, s_src_green, s_src_red};
            cd1_reg     <= {s_dest_blue, s_dest_green, s_dest_red};
        end
    end

    // ---------------------------------------------------------------
    // stage 2: denominator and channel products
    // ---------------------------------------------------------------
    logic          v2_reg;
    logic          inside2_reg;
    logic [CB-1:0] nsa2_reg;
    logic [DW-1:0] den2_reg;
    logic [NCH-1:0][DW-1:0] ps2_reg;
    logic [NCH-1:0][DW-1:0] pd2_reg;

    logic [CB-1:0] nsa2_next;
    logic [DW-1:0] den2_next;
    logic [NCH-1:0][DW-1:0] ps2_next;
    logic [NCH-1:0][DW-1:0] pd2_next;

    assign nsa2_next = aob_pkg::CH_MAX - sa1_reg;
    // 255*Sa as a shift and subtract
    assign den2_next = ({sa1_reg, {CB{1'b0}}} - DW'(sa1_reg))
                     + (DW'(da1_reg) * DW'(nsa2_next));

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            ps2_next[c] = DW'(cs1_reg[c]) * DW'(sa1_reg);
            pd2_next[c] = DW'(cd1_reg[c]) * DW'(da1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            inside2_reg <= inside1_reg;
            nsa2_reg    <= nsa2_next;
            den2_reg    <= den2_next;
            ps2_reg     <= ps2_next;
            pd2_reg     <= pd2_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: numerators and output alpha
    // ---------------------------------------------------------------
    logic              v3_reg;
    aob_pkg::aob_side_t side3_reg;
    logic [DW-1:0]     den3_reg;
    aob_pkg::num_vec_t num3_reg;

    aob_pkg::aob_side_t side3_next;
    aob_pkg::num_vec_t  num3_next;
    logic [DW:0]        den_inc;
    logic [DW:0]        div255;

    // floor(D/255) for 16-bit D: t = D+1, (t + (t >> 8)) >> 8
    assign den_inc = {1'b0, den2_reg} + (DW+1)'(1);
    assign div255  = den_inc + {{CB{1'b0}}, den_inc[DW:CB]};

    assign side3_next.in_clip = inside2_reg;
    assign side3_next.nonzero = (den2_reg != '0);
    assign side3_next.alpha   = div255[DW-1:CB];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            num3_next[c] = ({ps2_reg[c], {CB{1'b0}}} - NW'(ps2_reg[c]))
                         + (NW'(pd2_reg[c]) * NW'(nsa2_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side3_reg <= side3_next;
            den3_reg  <= den2_reg;
            num3_reg  <= num3_next;
        end
    end

    // ---------------------------------------------------------------
    // divider: one quotient bit per stage, flags ride alongside
    // ---------------------------------------------------------------
    aob_pkg::chan_vec_t quo;
    aob_pkg::aob_side_t side_reg [STEPS];
    logic [STEPS-1:0]   vd_reg;

    aob_div_pipe u_div (
        .aclk (aclk),
        .en   (adv),
        .num  (num3_reg),
        .den  (den3_reg),
        .quo  (quo)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side3_reg;
            for (int k = 1; k < STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic          m_write_enable_reg;
    logic [CB-1:0] m_out_red_reg;
    logic [CB-1:0] m_out_green_reg;
    logic [CB-1:0] m_out_blue_reg;
    logic [CB-1:0] m_out_alpha_reg;

    aob_pkg::aob_side_t side_last;
    logic               keep_color;
    aob_pkg::chan_vec_t color_next;
    logic [CB-1:0]      alpha_next;

    assign side_last  = side_reg[STEPS-1];
    // zero denominator or a clipped pixel gives zero channels
    assign keep_color = side_last.in_clip && side_last.nonzero;
    assign color_next = keep_color ? quo : '0;
    assign alpha_next = side_last.in_clip ? side_last.alpha : '0;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_write_enable_reg <= side_last.in_clip;
            m_out_red_reg      <= color_next[0];
            m_out_green_reg    <= color_next[1];
            m_out_blue_reg     <= color_next[2];
            m_out_alpha_reg    <= alpha_next;
        end
    end

    // valid bits, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            vd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            vd_reg      <= {vd_reg[STEPS-2:0], v3_reg};
            m_valid_reg <= vd_reg[STEPS-1];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_write_enable = m_write_enable_reg;
    assign m_out_red      = m_out_red_reg;
    assign m_out_green    = m_out_green_reg;
    assign m_out_blue     = m_out_blue_reg;
    assign m_out_alpha    = m_out_alpha_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    logic m_out_zero;

    assign m_out_zero = ({m_out_red_reg, m_out_green_reg, m_out_blue_reg,
                          m_out_alpha_reg} == '0);

    `AOB_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, v1_reg)
    `AOB_ASSERT_NEXT(a_stall_freezes, aclk, aresetn, !s_ready, $stable(vd_reg) && $stable(v3_reg))
    `AOB_ASSERT_SAME(a_clipped_zero, aclk, aresetn, m_valid_reg && !m_write_enable_reg, m_out_zero)

endmodule

`default_nettype wire

@@ rtl/aob_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage, three numerators
`default_nettype none

module aob_div_pipe (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire aob_pkg::num_vec_t                 num,
    input  wire logic [aob_pkg::DEN_W-1:0]         den,
    output aob_pkg::chan_vec_t                     quo
);

    localparam int STEPS = aob_pkg::DIV_STEPS;
    localparam int NW    = aob_pkg::NUM_W;
    localparam int DW    = aob_pkg::DEN_W;
    localparam int QW    = aob_pkg::CHANNEL_BITS;

    aob_pkg::num_vec_t  rem_reg [STEPS-1];
    aob_pkg::chan_vec_t quo_reg [STEPS];
    logic [DW-1:0]      den_reg [STEPS-1];

    genvar k, c;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            localparam int SHIFT = STEPS - 1 - k;

            aob_pkg::num_vec_t  rem_in;
            aob_pkg::chan_vec_t quo_in;
            logic [DW-1:0]      den_in;
            aob_pkg::num_vec_t  rem_next;
            aob_pkg::chan_vec_t quo_next;
            logic [NW-1:0]      den_sh;

            if (k == 0) begin : g_first
                assign rem_in = num;
                assign quo_in = '0;
                assign den_in = den;
            end else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            assign den_sh = {{(NW-DW){1'b0}}, den_in} << SHIFT;

            for (c = 0; c < aob_pkg::NUM_CH; c++) begin : g_ch
                logic [NW:0] diff;
                assign diff = {1'b0, rem_in[c]} - {1'b0, den_sh};
                // trial subtract, keep it when no borrow
                assign rem_next[c] = diff[NW] ? rem_in[c] : diff[NW-1:0];
                assign quo_next[c] = {quo_in[c][QW-2:0], ~diff[NW]};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    quo_reg[k] <= quo_next;
                end
            end

            if (k < STEPS - 1) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[k] <= rem_next;
                        den_reg[k] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[STEPS-1];

endmodule

`default_nettype wire
